[rtl/core/dlz_pkg.sv]
// Shared types and constants for the record LZ77 decompressor.
package dlz_pkg;

  localparam int HIST_DEPTH = 2048;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CNT_W      = 12;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_FLIP   = 8'h80;
  localparam logic [7:0] LIT_MAX     = 8'h7F;
  localparam logic [7:0] SPACE_FIRST = 8'hC0;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_BAD_DIST,
    STAT_OPEN_CODE
  } stat_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LIT,
    PH_COPY
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPACE2,
    ST_RD,
    ST_WR,
    ST_ERR2
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    stat_t      status;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [HIST_AW-1:0] raddr;
  } ram_req_t;

endpackage

[rtl/core/dlz_hist_ram.sv]
// History memory of produced bytes with one write port and one registered read port.
module dlz_hist_ram (
  input  logic            clk,
  input  dlz_pkg::ram_req_t req,
  output logic [7:0]      rdata
);
  import dlz_pkg::*;

  logic [7:0] mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[rtl/core/dlz_ctrl.sv]
// Decode sequencer: code parsing, record state and copy address stepping.
module dlz_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  input  logic              can_emit,
  output logic              emit,
  output dlz_pkg::res_t     res,
  output dlz_pkg::ram_req_t ram_req,
  input  logic [7:0]        ram_rdata
);
  import dlz_pkg::*;

  state_t             state, state_next;
  phase_t             phase, phase_next;
  logic               mode;
  logic [HIST_AW-1:0] wp, wp_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [3:0]         lit_left, lit_left_next;
  logic [5:0]         hi_bits, hi_bits_next;
  logic [HIST_AW-1:0] rd_ptr, rd_ptr_next;
  logic [3:0]         len_left, len_left_next;
  logic               pend, pend_next;
  logic [7:0]         hold, hold_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_IDLE;
      mode     <= 1'b1;
      wp       <= '0;
      count    <= '0;
      lit_left <= '0;
      hi_bits  <= '0;
      len_left <= '0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      wp       <= wp_next;
      count    <= count_next;
      lit_left <= lit_left_next;
      hi_bits  <= hi_bits_next;
      len_left <= len_left_next;
      pend     <= pend_next;
      if (cfg_wen) begin
        mode <= cfg_wdata;
      end
    end
    rd_ptr <= rd_ptr_next;
    hold   <= hold_next;
  end

  always_comb begin
    logic               accept;
    logic               prod;
    logic [7:0]         prod_data;
    logic               clr;
    logic [10:0]        copy_dist;
    logic [3:0]         lit_dec;
    logic [HIST_AW-1:0] src;

    state_next    = state;
    phase_next    = phase;
    wp_next       = wp;
    count_next    = count;
    lit_left_next = lit_left;
    hi_bits_next  = hi_bits;
    rd_ptr_next   = rd_ptr;
    len_left_next = len_left;
    pend_next     = pend;
    hold_next     = hold;
    emit          = 1'b0;
    res           = '0;
    ram_req       = '0;
    prod          = 1'b0;
    prod_data     = '0;
    clr           = 1'b0;
    copy_dist     = {hi_bits, in_byte[7:3]};
    lit_dec       = (lit_left != 4'd0) ? lit_left - 4'd1 : lit_left;
    src           = wp - HIST_AW'(copy_dist);

    in_ready = (state == ST_IDLE) && can_emit;
    accept   = in_valid && in_ready;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!mode) begin
            emit = 1'b1;
            res  = '{data: in_byte, last: 1'b1, status: STAT_OK};
            clr  = in_end;
          end else begin
            case (phase)
              PH_LIT: begin
                prod          = 1'b1;
                prod_data     = in_byte;
                emit          = 1'b1;
                lit_left_next = lit_dec;
                if (lit_dec == 4'd0) begin
                  phase_next = PH_IDLE;
                end
                res = '{data: in_byte, last: 1'b1, status: STAT_OK};
                if (in_end) begin
                  if (lit_dec != 4'd0) begin
                    res.last   = 1'b0;
                    state_next = ST_ERR2;
                  end else begin
                    clr = 1'b1;
                  end
                end
              end
              PH_COPY: begin
                phase_next   = PH_IDLE;
                hi_bits_next = '0;
                if (copy_dist == 11'd0 || {1'b0, copy_dist} > count) begin
                  emit = 1'b1;
                  res  = '{data: 8'd0, last: 1'b1, status: STAT_BAD_DIST};
                  clr  = in_end;
                end else begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = src;
                  rd_ptr_next   = src + HIST_AW'(1);
                  len_left_next = {1'b0, in_byte[2:0]} + 4'd3;
                  pend_next     = in_end;
                  state_next    = ST_WR;
                end
              end
              default: begin
                if (in_byte inside {[8'd1:8'd8]}) begin
                  lit_left_next = in_byte[3:0];
                  phase_next    = PH_LIT;
                  if (in_end) begin
                    emit = 1'b1;
                    res  = '{data: 8'd0, last: 1'b1, status: STAT_OPEN_CODE};
                    clr  = 1'b1;
                  end
                end else if (in_byte <= LIT_MAX) begin
                  prod      = 1'b1;
                  prod_data = in_byte;
                  emit      = 1'b1;
                  res       = '{data: in_byte, last: 1'b1, status: STAT_OK};
                  clr       = in_end;
                end else if (in_byte >= SPACE_FIRST) begin
                  prod       = 1'b1;
                  prod_data  = BYTE_SPACE;
                  emit       = 1'b1;
                  res        = '{data: BYTE_SPACE, last: 1'b0, status: STAT_OK};
                  hold_next  = in_byte ^ BYTE_FLIP;
                  pend_next  = in_end;
                  state_next = ST_SPACE2;
                end else begin
                  hi_bits_next = in_byte[5:0];
                  phase_next   = PH_COPY;
                  if (in_end) begin
                    emit = 1'b1;
                    res  = '{data: 8'd0, last: 1'b1, status: STAT_OPEN_CODE};
                    clr  = 1'b1;
                  end
                end
              end
            endcase
          end
        end
      end
      ST_SPACE2: begin
        if (can_emit) begin
          prod       = 1'b1;
          prod_data  = hold;
          emit       = 1'b1;
          res        = '{data: hold, last: 1'b1, status: STAT_OK};
          clr        = pend;
          state_next = ST_IDLE;
        end
      end
      ST_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = rd_ptr;
        rd_ptr_next   = rd_ptr + HIST_AW'(1);
        state_next    = ST_WR;
      end
      ST_WR: begin
        if (can_emit) begin
          prod          = 1'b1;
          prod_data     = ram_rdata;
          emit          = 1'b1;
          len_left_next = len_left - 4'd1;
          res           = '{data: ram_rdata, last: 1'b0, status: STAT_OK};
          if (len_left == 4'd1) begin
            res.last   = 1'b1;
            clr        = pend;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_ERR2: begin
        if (can_emit) begin
          emit       = 1'b1;
          res        = '{data: 8'd0, last: 1'b1, status: STAT_OPEN_CODE};
          clr        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (prod) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = wp;
      ram_req.wdata = prod_data;
      wp_next       = wp + HIST_AW'(1);
      count_next    = (count == CNT_MAX) ? count : count + CNT_W'(1);
    end

    if (clr) begin
      wp_next       = '0;
      count_next    = '0;
      phase_next    = PH_IDLE;
      lit_left_next = '0;
      hi_bits_next  = '0;
    end
  end

endmodule

[rtl/core/doc_record_lz77_decompressor.sv]
// Top level of the record LZ77 decompressor with its output register.
// One compressed byte is taken per transfer and its decoded bytes leave through an output
// register; the next byte is taken once the sequencer is idle and the output register is
// free or is being emptied in the same cycle. Bypass bytes, plain bytes and literal-run
// bytes each give one result; a byte that opens a literal run or a copy gives no result; a
// space-pair code gives a space and then a second byte; for the second byte of a copy code
// the first history read is issued as that byte is taken, and each copied byte is then
// written back and emitted and, but for the last, the next byte is read from the 2048-byte
// history RAM, whose read port is registered. A copy with a bad distance gives a single
// status result. A record that ends inside a literal run gets a separate status result
// after its last literal; when it ends on a byte that opens a code, the status leaves in
// the same cycle. A stall on the output side holds every step that gives a result. The
// history RAM needs no clearing after reset: a copy only reads bytes written earlier in
// the same record.
module doc_record_lz77_decompressor (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,      // compressed_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // record_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // last_of_run
  output logic [1:0] m_axis_tuser    // [1:0] status
);
  import dlz_pkg::*;

  logic     can_emit;
  logic     emit;
  res_t     res;
  res_t     out_res;
  logic     out_valid;
  ram_req_t ram_req;
  logic [7:0] ram_rdata;

  assign can_emit = !out_valid || m_axis_tready;

  dlz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_end    (s_axis_tlast),
    .can_emit  (can_emit),
    .emit      (emit),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  dlz_hist_ram u_hist (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_emit) begin
      out_valid <= emit;
    end
    if (can_emit && emit) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tlast  = out_res.last;
  assign m_axis_tuser  = out_res.status;

endmodule
